@@ design/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Request and status codes, field widths and the control/status structs
// passed between the controller and the datapath. No dependencies.
package deq_pkg;

    localparam int DEQ_DEPTH = 64;
    localparam int REQ_W     = 3;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_DUMP_FWD   = 3'd4,
        REQ_DUMP_BACK  = 3'd5
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    cap;      // capture the input beat
        logic    push;     // write the held value and grow the queue
        logic    pop;      // read one end and shrink the queue
        logic    dump_rd;  // read the entry at the dump offset
        logic    out_imm;  // load a result with zero data
        t_status out_st;   // status for out_imm
        logic    out_mem;  // load a result from the read data
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req req;
        logic empty;
        logic full;
        logic out_free;
        logic rd_last;
    } t_sts;

endpackage

@@ design/double_ended_queue.sv @@
// Top level of the double-ended queue of signed 32-bit values.
// Depends on deq_pkg, deq_ctrl, deq_dp (and deq_ram through deq_dp).
//
//   Channel   Direction  tdata                 tuser               tlast
//   s_axis    in         value [31:0]          req_type [2:0]      -
//   m_axis    out        data [31:0]           status [1:0]        last
//
// Each request beat is held in a request register and then executed against
// a ring RAM of DEPTH entries, tracked by a front index and an entry count.
// A push loads its result into the output register when it executes; a pop
// reads the RAM through its registered read port and then loads the read
// data into the single output register; a dump does the same for each entry
// in turn. The next request beat is accepted as soon as the current
// one has handed its last result to the output register, even while that
// result still waits on m_axis_tready. A stalled output holds the sequencer
// before each new result. Reset (synchronous, active low) empties the queue;
// the RAM contents are not cleared and need no clearing pass.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [deq_pkg::VAL_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [deq_pkg::REQ_W-1:0]         s_axis_tuser,   // [2:0] req_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic signed [deq_pkg::VAL_W-1:0]  m_axis_tdata,   // [31:0] data
    output logic [deq_pkg::ST_W-1:0]          m_axis_tuser,   // [1:0] status
    output logic                              m_axis_tlast    // last
);

    deq_pkg::t_cmd w_cmd;
    deq_pkg::t_sts w_sts;

    // The controller owns the sequencing; the datapath owns all storage.
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req        (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

@@ design/deq_ram.sv @@
// Generic single-clock RAM: one write port and one read port with a
// registered read. No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/deq_dp.sv @@
// Datapath of the double-ended queue: request holding register, front index,
// entry count, dump offset, ring address logic, entry RAM and output register.
// Depends on deq_pkg and deq_ram.
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  deq_pkg::t_cmd              i_cmd,
    output deq_pkg::t_sts              o_sts,
    input  logic [deq_pkg::REQ_W-1:0]  i_req,
    input  logic [deq_pkg::VAL_W-1:0]  i_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [deq_pkg::ST_W-1:0]   o_out_status,
    output logic [deq_pkg::VAL_W-1:0]  o_out_data,
    output logic                       o_out_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::t_req              r_req;
    logic [deq_pkg::VAL_W-1:0]  r_value;
    logic [IW-1:0]              r_front;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_ofs;
    logic                       r_rd_last;
    logic                       r_out_valid;
    deq_pkg::t_status           r_out_status;
    logic [deq_pkg::VAL_W-1:0]  r_out_data;
    logic                       r_out_last;

    logic [CW-1:0]              w_ofs_sel;
    logic [CW:0]                w_sum;
    logic [IW-1:0]              w_slot;
    logic [IW-1:0]              w_front_dec;
    logic [IW-1:0]              w_front_inc;
    logic [IW-1:0]              w_waddr;
    logic [IW-1:0]              w_raddr;
    logic [deq_pkg::VAL_W-1:0]  w_rdata;

    // Offset from the front that the current request addresses.
    always_comb begin
        case (r_req)
            deq_pkg::REQ_PUSH_BACK: w_ofs_sel = r_count;
            deq_pkg::REQ_POP_BACK:  w_ofs_sel = r_count - CW'(1);
            deq_pkg::REQ_DUMP_FWD:  w_ofs_sel = r_ofs;
            deq_pkg::REQ_DUMP_BACK: w_ofs_sel = r_count - CW'(1) - r_ofs;
            default:                w_ofs_sel = '0;
        endcase
    end

    // Both operands stay below DEPTH, so one conditional subtract wraps the sum.
    assign w_sum  = (CW+1)'(r_front) + (CW+1)'(w_ofs_sel);
    assign w_slot = (w_sum >= (CW+1)'(DEPTH)) ? IW'(w_sum - (CW+1)'(DEPTH)) : IW'(w_sum);

    assign w_front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);
    assign w_front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + IW'(1);

    assign w_waddr = (r_req == deq_pkg::REQ_PUSH_FRONT) ? w_front_dec : w_slot;
    assign w_raddr = (r_req == deq_pkg::REQ_POP_FRONT) ? r_front : w_slot;

    deq_ram #(
        .WIDTH (deq_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_ofs       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_ofs <= '0;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
                if (r_req == deq_pkg::REQ_PUSH_FRONT) begin
                    r_front <= w_front_dec;
                end
            end
            if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                if (r_req == deq_pkg::REQ_POP_FRONT) begin
                    r_front <= w_front_inc;
                end
            end
            if (i_cmd.dump_rd) begin
                r_ofs <= r_ofs + CW'(1);
            end
            if (i_cmd.out_imm || i_cmd.out_mem) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req   <= deq_pkg::t_req'(i_req);
            r_value <= i_value;
        end
        if (i_cmd.pop) begin
            r_rd_last <= 1'b1;
        end else if (i_cmd.dump_rd) begin
            r_rd_last <= (r_ofs == r_count - CW'(1));
        end
        if (i_cmd.out_imm) begin
            r_out_status <= i_cmd.out_st;
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_mem) begin
            r_out_status <= deq_pkg::ST_OK;
            r_out_data   <= w_rdata;
            r_out_last   <= r_rd_last;
        end
    end

    assign o_sts.req      = r_req;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.rd_last  = r_rd_last;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

endmodule

@@ design/deq_ctrl.sv @@
// Controller of the double-ended queue: sequences capture, execution, RAM
// reads and result loads. Depends on deq_pkg.
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DUMP
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_ready;
    deq_pkg::t_cmd w_cmd;

    always_comb begin
        n_state      = r_state;
        w_cmd        = '0;
        w_cmd.out_st = deq_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    case (i_sts.req) inside
                        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
                            w_cmd.out_imm = 1'b1;
                            if (i_sts.full) begin
                                w_cmd.out_st = deq_pkg::ST_FULL;
                            end else begin
                                w_cmd.push = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
                            if (i_sts.empty) begin
                                w_cmd.out_imm = 1'b1;
                                w_cmd.out_st  = deq_pkg::ST_EMPTY;
                                n_state       = S_IDLE;
                            end else begin
                                w_cmd.pop = 1'b1;
                                n_state   = S_LOAD;
                            end
                        end
                        deq_pkg::REQ_DUMP_FWD, deq_pkg::REQ_DUMP_BACK: begin
                            if (i_sts.empty) begin
                                w_cmd.out_imm = 1'b1;
                                w_cmd.out_st  = deq_pkg::ST_EMPTY;
                                n_state       = S_IDLE;
                            end else begin
                                w_cmd.dump_rd = 1'b1;
                                n_state       = S_LOAD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // The read was issued only when the output register was free.
                w_cmd.out_mem = 1'b1;
                n_state       = i_sts.rd_last ? S_IDLE : S_DUMP;
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    w_cmd.dump_rd = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;
    assign o_cmd      = w_cmd;

endmodule

@@ design/deq_checker.sv @@
// Port-level assertions for the double-ended queue, bound to its top level.
// Depends on deq_pkg and double_ended_queue.
module deq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [deq_pkg::VAL_W-1:0]  s_axis_tdata,
    input logic [deq_pkg::REQ_W-1:0]  s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [deq_pkg::VAL_W-1:0]  m_axis_tdata,
    input logic [deq_pkg::ST_W-1:0]   m_axis_tuser,
    input logic                       m_axis_tlast
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Error results end their request and carry zero data.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != deq_pkg::ST_OK) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("error result without last or with data");

    // A request is executed before the next one is taken.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken in back-to-back cycles");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
